// ===== rtl/rdc_pkg.sv =====
// Shared types and constants for the radix digit converter.
package rdc_pkg;

  localparam int DATA_W      = 64;
  localparam int RADIX_W     = 5;
  localparam int CHAR_W      = 8;
  localparam int COUNT_W     = 7;
  localparam int DIGIT_W     = 4;
  localparam int NIB_W       = 4;
  localparam int STEPS       = DATA_W / NIB_W;
  localparam int STEP_W      = $clog2(STEPS);
  localparam int CFG_INDEX_W = 2;

  localparam int DEF_MAX_DIGITS = 64;
  localparam int MAX_RADIX      = 16;

  localparam logic [RADIX_W-1:0] RADIX_RESET  = 5'd10;
  localparam logic [DATA_W-1:0]  DIGITS_LO_RESET = 64'h3736353433323130;
  localparam logic [DATA_W-1:0]  DIGITS_HI_RESET = 64'h6665646362613938;

  localparam logic [CFG_INDEX_W-1:0] CFG_RADIX     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIGITS_LO = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIGITS_HI = 2'd2;

  typedef struct packed {
    logic               done;
    logic               busy;
    logic               quot_zero;
    logic [DIGIT_W-1:0] rem;
  } div_stat_t;

endpackage

// ===== rtl/rdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rdc_divider.sv =====
// Nibble-serial divider: 64-bit dividend by a small radix, four bits per cycle.
module rdc_divider
  import rdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DATA_W-1:0]  din,
  input  logic [RADIX_W-1:0] radix,
  output div_stat_t          stat,
  output logic [DATA_W-1:0]  quot
);

  logic [DIGIT_W-1:0] rem;
  logic [STEP_W-1:0]  step_cnt;
  logic               busy;
  logic               done;
  logic               nonzero;
  logic [NIB_W-1:0]   nib;
  logic [NIB_W-1:0]   qnib;
  logic [DIGIT_W-1:0] rem_next;

  assign nib = quot[DATA_W-1 -: NIB_W];

  // restoring division over one nibble, remainder stays below radix
  always_comb begin
    logic [DIGIT_W:0] t;
    logic [DIGIT_W-1:0] r;
    r    = rem;
    qnib = '0;
    for (int i = NIB_W - 1; i >= 0; i--) begin
      t = {r, nib[i]};
      if (t >= radix) begin
        t       = t - radix;
        qnib[i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step_cnt == STEP_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot     <= din;
      rem      <= '0;
      step_cnt <= '0;
      nonzero  <= 1'b0;
    end else if (busy) begin
      quot     <= {quot[DATA_W-NIB_W-1:0], qnib};
      rem      <= rem_next;
      nonzero  <= nonzero | (qnib != '0);
      step_cnt <= step_cnt + 1'b1;
    end
  end

  assign stat.done      = done;
  assign stat.busy      = busy;
  assign stat.quot_zero = !nonzero;
  assign stat.rem       = rem;

endmodule

// ===== rtl/radix_digit_converter_unit.sv =====
// Top level of the radix digit converter: control, registers, digit store and output beat.
//
//   channel | direction | handshake                | payload
//   input   | in        | in_valid / in_ready      | value[63:0]
//   output  | out       | out_valid / out_ready    | digit_char, last_digit, digit_count
//   config  | in        | cfg_write                | cfg_index, cfg_data
//
// Each digit: 16 steps in the nibble-serial divider, then a store write of its remainder.
// Each character then needs a store read and an output load.
// One value at a time; in_ready is high only while idle: no division, all store reads issued.
// A stalled output beat holds the readout; the next value may enter while the last beat waits.
// Reset is synchronous and clears control state; the digit store needs no clearing.
module radix_digit_converter_unit
  import rdc_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [DATA_W-1:0]      value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CHAR_W-1:0]      digit_char,
  output logic                   last_digit,
  output logic [COUNT_W-1:0]     digit_count,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data
);

  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]         state;
  logic [RADIX_W-1:0] radix;
  logic [DATA_W-1:0]  digits_lo;
  logic [DATA_W-1:0]  digits_hi;
  logic [CNT_W-1:0]   n;
  logic [AW-1:0]      pos;
  logic               rd_pend;
  logic               pend_last;
  logic [CNT_W-1:0]   pend_count;

  div_stat_t          stat;
  logic [DATA_W-1:0]  quot;
  logic               div_start;
  logic               finish;
  logic               store_we;
  logic               issue;
  logic               in_beat;
  logic [DIGIT_W-1:0] rdata;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_W'(2)) begin
      return RADIX_W'(2);
    end
    if (r > RADIX_W'(MAX_RADIX)) begin
      return RADIX_W'(MAX_RADIX);
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] idx,
                                                input logic [2*DATA_W-1:0] alpha);
    return alpha[idx*CHAR_W +: CHAR_W];
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign store_we  = (state == S_DIV) && stat.done;
  assign finish    = stat.quot_zero || (n == CNT_W'(MAX_DIGITS - 1));
  assign div_start = in_beat || (store_we && !finish);
  assign issue     = (state == S_EMIT) && !rd_pend && (!out_valid || out_ready);

  rdc_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .din   ((state == S_IDLE) ? value : quot),
    .radix (radix),
    .stat  (stat),
    .quot  (quot)
  );

  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (n[AW-1:0]),
    .wdata (stat.rem),
    .re    (issue),
    .raddr (pos),
    .rdata (rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= RADIX_RESET;
      digits_lo <= DIGITS_LO_RESET;
      digits_hi <= DIGITS_HI_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RADIX:     radix     <= clamp_radix(cfg_data[RADIX_W-1:0]);
        CFG_DIGITS_LO: digits_lo <= cfg_data;
        CFG_DIGITS_HI: digits_hi <= cfg_data;
        default:       ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      n       <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= issue;
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            n     <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (stat.done) begin
            n <= n + 1'b1;
            if (finish) begin
              pos   <= n[AW-1:0];
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (issue) begin
            pend_last  <= (pos == '0);
            pend_count <= n;
            if (pos == '0) begin
              state <= S_IDLE;
            end else begin
              pos <= pos - 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      digit_char  <= char_of(rdata, {digits_hi, digits_lo});
      last_digit  <= pend_last;
      digit_count <= COUNT_W'(pend_count);
    end
  end

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_valid) else $error("store read lands on a full output beat");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == S_DIV) else $error("divider done outside division");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> n < CNT_W'(MAX_DIGITS)) else $error("digit count past store depth");

  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.busy) else $error("input ready while divider busy");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for radix_digit_converter_unit, checked per character.
`timescale 1ns / 100ps

module testbench;
  import rdc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 6000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 17;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               is_last;
    logic [COUNT_W-1:0] count;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [DATA_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CHAR_W-1:0] digit_char;
  logic last_digit;
  logic [COUNT_W-1:0] digit_count;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  logic [DATA_W-1:0] pending_values[$];
  char_beat_t expected_chars[$];
  logic [RADIX_W-1:0] base = RADIX_RESET;
  logic [DATA_W-1:0] alpha_lo = DIGITS_LO_RESET;
  logic [DATA_W-1:0] alpha_hi = DIGITS_HI_RESET;
  logic quiet = 1'b0;
  int in_gap = 0;
  int out_hold = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  radix_digit_converter_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .digit_char(digit_char), .last_digit(last_digit), .digit_count(digit_count),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] idx);
    if (idx < 8) return alpha_lo[8*idx +: 8];
    return alpha_hi[8*(idx-8) +: 8];
  endfunction

  // Repeated division, then characters most significant first.
  task automatic predict_conversion(input logic [DATA_W-1:0] v);
    logic [DIGIT_W-1:0] found[DEF_MAX_DIGITS];
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] r;
    int n;
    int k;
    q = v;
    r = DATA_W'(base);
    n = 0;
    do begin
      found[n] = DIGIT_W'(q % r);
      q = q / r;
      n++;
    end while (q != 0 && n < DEF_MAX_DIGITS);
    for (k = n - 1; k >= 0; k--) begin
      expected_chars.push_back('{char_of(found[k]), k == 0, COUNT_W'(n)});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (in_valid && !in_ready) begin
    end else if (in_gap != 0) begin
      in_gap <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_values.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
      in_gap <= $urandom_range(0, 2);
      in_valid <= 1'b0;
    end else if (pending_values.size() != 0) begin
      in_valid <= 1'b1;
      value <= pending_values.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold <= 0;
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_hold <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    char_beat_t want;
    if (!rst) begin
      if (in_valid && in_ready) predict_conversion(value);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got char %h last %b count %0d",
                   $time, digit_char, last_digit, digit_count);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (digit_char !== want.ch) begin
            $display("%0t: digit_char expected %h got %h", $time, want.ch, digit_char);
            mismatches++;
          end
          if (last_digit !== want.is_last) begin
            $display("%0t: last_digit expected %b got %b", $time, want.is_last, last_digit);
            mismatches++;
          end
          if (digit_count !== want.count) begin
            $display("%0t: digit_count expected %0d got %0d", $time, want.count, digit_count);
            mismatches++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_RADIX:     base = (data[4:0] < 2) ? 5'd2 :
                            (data[4:0] > MAX_RADIX) ? RADIX_W'(MAX_RADIX) : data[4:0];
      CFG_DIGITS_LO: alpha_lo = data;
      CFG_DIGITS_HI: alpha_hi = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_values.size() != 0 || in_valid || expected_chars.size() != 0);
  endtask

  initial begin
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] rdata;
    int p;
    int i;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset alphabet, decimal
    pending_values = '{64'd0, 64'd1, 64'd9, 64'd10, '1, 64'd10000000000000000000};
    wait_idle();

    // radix below range clamps to binary
    write_reg(CFG_RADIX, 64'd1);
    pending_values = '{64'd0, 64'd1, '1, 64'h8000_0000_0000_0000};
    wait_idle();

    // radix above range clamps to 16
    write_reg(CFG_RADIX, 64'd31);
    pending_values = '{'1, 64'h0123_4567_89AB_CDEF, 64'h0000_0000_0000_000F};
    wait_idle();

    // alphabet with zero bytes; unused index ignored
    write_reg(CFG_DIGITS_LO, 64'h00FF_80A5_5A01_7E00);
    write_reg(CFG_DIGITS_HI, 64'hFF00_C3A5_7F80_0102);
    write_reg(CFG_UNUSED, '1);
    pending_values = '{64'hFEDC_BA98_7654_3210, 64'd0, 64'h0000_0000_0000_1008};
    wait_idle();

    // only low five radix bits count
    write_reg(CFG_RADIX, 64'hFFFF_FFFF_FFFF_FFE3);
    pending_values = '{'1, 64'd2, 64'd3};
    wait_idle();

    for (p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: rdata = {$urandom, $urandom} & ~64'h1F | 64'($urandom_range(0, 1));
        1: rdata = {$urandom, $urandom} & ~64'h1F | 64'($urandom_range(16, 31));
        default: rdata = {$urandom, $urandom} & ~64'h1F | 64'($urandom_range(2, 16));
      endcase
      write_reg(CFG_RADIX, rdata);
      if ($urandom_range(0, 1)) write_reg(CFG_DIGITS_LO, {$urandom, $urandom});
      if ($urandom_range(0, 1)) write_reg(CFG_DIGITS_HI, {$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
      if (p == RAND_PHASES - 1) quiet = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = '1;
          default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        pending_values.push_back(v);
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rdc_pkg.sv
rtl/rdc_ram.sv
rtl/rdc_divider.sv
rtl/radix_digit_converter_unit.sv
tb/testbench.sv
